@@ hw/rtl/keyed_alphabet_mutation_unit_defines.svh @@
// assertion macros shared by the keyed alphabet mutation unit
// no dependencies; included by the controller and the datapath
`ifndef KEYED_ALPHABET_MUTATION_UNIT_DEFINES_SVH
`define KEYED_ALPHABET_MUTATION_UNIT_DEFINES_SVH

// same-cycle implication
`define KAMU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kamu check failed: same-cycle implication");

// next-cycle implication
`define KAMU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kamu check failed: next-cycle implication");

`endif

@@ hw/rtl/kamu_pkg.sv @@
// shared types, codes and constants of the keyed alphabet mutation unit
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package kamu_pkg;

    localparam int CELL_W       = 5;
    localparam int IDX_W        = 5;
    localparam int CELL_SLOTS   = 32;
    localparam int PACKED_CELLS = 24;
    localparam int HALF_CELLS   = 12;
    localparam int HALF_W       = 60;
    localparam int LOAD_LEN_W   = 4;
    localparam int OUT_LEN_W    = 4;
    localparam int CALC_W       = 6;
    localparam int THR_W        = 16;

    localparam int ALPHABET_SIZE_DEF = 24;
    localparam int KEYWORD_MIN_DEF   = 3;
    localparam int KEYWORD_MAX_DEF   = 12;

    localparam logic [THR_W-1:0] RESIZE_THR_RESET   = 16'd2621;
    localparam logic [THR_W-1:0] EXCHANGE_THR_RESET = 16'd34079;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register index, taken from the word address bit
    localparam logic REG_IDX_RESIZE   = 1'b0;
    localparam logic REG_IDX_EXCHANGE = 1'b1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_MOVE = 1'b1;

    typedef enum logic [1:0] {
        KIND_LOAD     = 2'd0,
        KIND_RESIZE   = 2'd1,
        KIND_EXCHANGE = 2'd2,
        KIND_REORDER  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        DP_IDLE    = 3'd0,
        DP_SWAP_A  = 3'd1,
        DP_SWAP_B  = 3'd2,
        DP_SWAP_C  = 3'd3,
        DP_REBUILD = 3'd4
    } dp_op_t;

    typedef struct packed {
        logic   accept;
        logic   rebuild_start;
        dp_op_t op;
    } ctrl_cmd_t;

    typedef struct packed {
        kind_t kind_in;
        logic  err_in;
        kind_t kind;
        logic  rebuild_last;
    } dp_status_t;

endpackage

@@ hw/rtl/keyed_alphabet_mutation_unit.sv @@
// top level of the keyed alphabet mutation unit
// depends on kamu_pkg, kamu_regs, kamu_ctrl and kamu_datapath
`timescale 1ns / 1ps

// A beat is taken at a rising edge with start high and busy low. Its result is
// shown for exactly one cycle with done high and cannot be held off, so sample it
// then. A load, or a move whose positions are out of range, gives its result in
// the cycle right after the beat, and a new beat may be taken in that same done
// cycle, so such beats run at one per cycle. A reorder runs its swap in steps:
// the cell store has one read and one write port, so a swap needs three steps.
// A resize runs the tail rebuild, and an exchange its swap and then the tail
// rebuild, which tests one candidate letter per cycle. The user must write the
// thresholds over the apb-style port while the block is idle; it is not enforced.

module keyed_alphabet_mutation_unit #(
    parameter int ALPHABET_SIZE = kamu_pkg::ALPHABET_SIZE_DEF,
    parameter int KEYWORD_MIN   = kamu_pkg::KEYWORD_MIN_DEF,
    parameter int KEYWORD_MAX   = kamu_pkg::KEYWORD_MAX_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            operation,
    input  logic [kamu_pkg::HALF_W-1:0]     load_lower_half,
    input  logic [kamu_pkg::HALF_W-1:0]     load_upper_half,
    input  logic [kamu_pkg::LOAD_LEN_W-1:0] load_keyword_length,
    input  logic [kamu_pkg::THR_W-1:0]      draw,
    input  logic                            coin,
    input  logic [kamu_pkg::IDX_W-1:0]      first_pos,
    input  logic [kamu_pkg::IDX_W-1:0]      second_pos,
    output logic                            done,
    output logic [kamu_pkg::HALF_W-1:0]     alphabet_lower_half,
    output logic [kamu_pkg::HALF_W-1:0]     alphabet_upper_half,
    output logic [kamu_pkg::OUT_LEN_W-1:0]  keyword_length_now,
    output logic [1:0]                      move_kind,
    output logic                            position_error,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [kamu_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [kamu_pkg::APB_DATA_W-1:0] pwdata,
    output logic [kamu_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import kamu_pkg::*;

    ctrl_cmd_t        cmd;
    dp_status_t       status;
    logic [THR_W-1:0] resize_thr;
    logic [THR_W-1:0] exchange_thr;

    kamu_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .resize_thr   (resize_thr),
        .exchange_thr (exchange_thr)
    );

    kamu_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd),
        .status (status)
    );

    kamu_datapath #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .KEYWORD_MIN   (KEYWORD_MIN),
        .KEYWORD_MAX   (KEYWORD_MAX)
    ) u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .status              (status),
        .resize_thr          (resize_thr),
        .exchange_thr        (exchange_thr),
        .operation           (operation),
        .load_lower_half     (load_lower_half),
        .load_upper_half     (load_upper_half),
        .load_keyword_length (load_keyword_length),
        .draw                (draw),
        .coin                (coin),
        .first_pos           (first_pos),
        .second_pos          (second_pos),
        .alphabet_lower_half (alphabet_lower_half),
        .alphabet_upper_half (alphabet_upper_half),
        .keyword_length_now  (keyword_length_now),
        .move_kind           (move_kind),
        .position_error      (position_error)
    );

endmodule

@@ hw/rtl/kamu_regs.sv @@
// configuration registers behind the apb-style port: the two draw thresholds
// depends on kamu_pkg
`timescale 1ns / 1ps

module kamu_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [kamu_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [kamu_pkg::APB_DATA_W-1:0] pwdata,
    output logic [kamu_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output logic [kamu_pkg::THR_W-1:0]      resize_thr,
    output logic [kamu_pkg::THR_W-1:0]      exchange_thr
);
    import kamu_pkg::*;

    logic [THR_W-1:0] resize_thr_reg;
    logic [THR_W-1:0] resize_thr_next;
    logic [THR_W-1:0] exchange_thr_reg;
    logic [THR_W-1:0] exchange_thr_next;
    logic             wr_beat;

    assign pready  = 1'b1;
    assign wr_beat = psel && penable && pwrite;

    always_comb
    begin
        resize_thr_next   = resize_thr_reg;
        exchange_thr_next = exchange_thr_reg;
        if (wr_beat)
        begin
            case (paddr[2])
                REG_IDX_RESIZE:   resize_thr_next   = pwdata[THR_W-1:0];
                REG_IDX_EXCHANGE: exchange_thr_next = pwdata[THR_W-1:0];
                default:          resize_thr_next   = resize_thr_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_IDX_RESIZE:   prdata = APB_DATA_W'(resize_thr_reg);
            REG_IDX_EXCHANGE: prdata = APB_DATA_W'(exchange_thr_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resize_thr_reg   <= RESIZE_THR_RESET;
            exchange_thr_reg <= EXCHANGE_THR_RESET;
        end
        else
        begin
            resize_thr_reg   <= resize_thr_next;
            exchange_thr_reg <= exchange_thr_next;
        end
    end

    assign resize_thr   = resize_thr_reg;
    assign exchange_thr = exchange_thr_reg;

endmodule

@@ hw/rtl/kamu_ctrl.sv @@
// sequencer of the keyed alphabet mutation unit: handshake, swap steps, tail rebuild
// depends on kamu_pkg and keyed_alphabet_mutation_unit_defines.svh
`timescale 1ns / 1ps
`include "keyed_alphabet_mutation_unit_defines.svh"

module kamu_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    output logic                   done,
    output kamu_pkg::ctrl_cmd_t    cmd,
    input  kamu_pkg::dp_status_t   status
);
    import kamu_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_SWAP_A  = 6'b000010,
        ST_SWAP_B  = 6'b000100,
        ST_SWAP_C  = 6'b001000,
        ST_REBUILD = 6'b010000,
        ST_FINISH  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   open_for_beat;
    logic   take_beat;
    logic   rebuild_start;
    dp_op_t op_now;

    // the result cycle also takes a new beat
    assign open_for_beat = state_reg inside {ST_IDLE, ST_FINISH};
    assign busy          = !open_for_beat;
    assign done          = (state_reg == ST_FINISH);
    assign take_beat     = start && open_for_beat;
    assign cmd           = '{accept: take_beat, rebuild_start: rebuild_start, op: op_now};

    always_comb
    begin
        case (state_reg)
            ST_SWAP_A:  op_now = DP_SWAP_A;
            ST_SWAP_B:  op_now = DP_SWAP_B;
            ST_SWAP_C:  op_now = DP_SWAP_C;
            ST_REBUILD: op_now = DP_REBUILD;
            default:    op_now = DP_IDLE;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        rebuild_start = 1'b0;
        case (state_reg)
            ST_IDLE, ST_FINISH:
            begin
                state_next = ST_IDLE;
                if (take_beat)
                begin
                    case (status.kind_in)
                        KIND_LOAD:
                            state_next = ST_FINISH;
                        KIND_RESIZE:
                        begin
                            state_next    = ST_REBUILD;
                            rebuild_start = 1'b1;
                        end
                        default:
                            state_next = status.err_in ? ST_FINISH : ST_SWAP_A;
                    endcase
                end
            end
            ST_SWAP_A:
                state_next = ST_SWAP_B;
            ST_SWAP_B:
                state_next = ST_SWAP_C;
            ST_SWAP_C:
            begin
                if (status.kind == KIND_EXCHANGE)
                begin
                    state_next    = ST_REBUILD;
                    rebuild_start = 1'b1;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_REBUILD:
                state_next = status.rebuild_last ? ST_FINISH : ST_REBUILD;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `KAMU_ASSERT_NEXT(a_load_result_next, clk, rst_n,
        take_beat && (status.kind_in == KIND_LOAD), done)
    `KAMU_ASSERT_NEXT(a_rebuild_exit, clk, rst_n, (state_reg == ST_REBUILD) && status.rebuild_last, done)
    `KAMU_ASSERT_NEXT(a_bad_pos_no_swap, clk, rst_n, take_beat && status.err_in, done)

endmodule

@@ hw/rtl/kamu_datapath.sv @@
// alphabet cells, keyword length, move decode, swap port and tail rebuild
// depends on kamu_pkg and keyed_alphabet_mutation_unit_defines.svh
`timescale 1ns / 1ps
`include "keyed_alphabet_mutation_unit_defines.svh"

module kamu_datapath #(
    parameter int ALPHABET_SIZE = kamu_pkg::ALPHABET_SIZE_DEF,
    parameter int KEYWORD_MIN   = kamu_pkg::KEYWORD_MIN_DEF,
    parameter int KEYWORD_MAX   = kamu_pkg::KEYWORD_MAX_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  kamu_pkg::ctrl_cmd_t             cmd,
    output kamu_pkg::dp_status_t            status,
    input  logic [kamu_pkg::THR_W-1:0]      resize_thr,
    input  logic [kamu_pkg::THR_W-1:0]      exchange_thr,
    input  logic                            operation,
    input  logic [kamu_pkg::HALF_W-1:0]     load_lower_half,
    input  logic [kamu_pkg::HALF_W-1:0]     load_upper_half,
    input  logic [kamu_pkg::LOAD_LEN_W-1:0] load_keyword_length,
    input  logic [kamu_pkg::THR_W-1:0]      draw,
    input  logic                            coin,
    input  logic [kamu_pkg::IDX_W-1:0]      first_pos,
    input  logic [kamu_pkg::IDX_W-1:0]      second_pos,
    output logic [kamu_pkg::HALF_W-1:0]     alphabet_lower_half,
    output logic [kamu_pkg::HALF_W-1:0]     alphabet_upper_half,
    output logic [kamu_pkg::OUT_LEN_W-1:0]  keyword_length_now,
    output logic [1:0]                      move_kind,
    output logic                            position_error
);
    import kamu_pkg::*;

    localparam int POS_W  = $clog2(ALPHABET_SIZE + 1);
    localparam int KLEN_W = $clog2(KEYWORD_MAX + 1);

    function automatic logic [CALC_W-1:0] clamp_len(input logic [CALC_W-1:0] k);
        logic [CALC_W-1:0] r;
        r = k;
        if (r < CALC_W'(KEYWORD_MIN))
            r = CALC_W'(KEYWORD_MIN);
        if (r > CALC_W'(KEYWORD_MAX))
            r = CALC_W'(KEYWORD_MAX);
        if (r > CALC_W'(ALPHABET_SIZE))
            r = CALC_W'(ALPHABET_SIZE);
        return r;
    endfunction

    logic [CELL_W-1:0] cells_reg  [CELL_SLOTS];
    logic [CELL_W-1:0] cells_next [CELL_SLOTS];
    logic [KLEN_W-1:0] klen_reg;
    logic [KLEN_W-1:0] klen_next;
    kind_t             kind_reg;
    kind_t             kind_next;
    logic              err_reg;
    logic              err_next;
    logic [IDX_W-1:0]  p1_reg;
    logic [IDX_W-1:0]  p1_next;
    logic [IDX_W-1:0]  p2_reg;
    logic [IDX_W-1:0]  p2_next;
    logic [CELL_W-1:0] tmp_reg;
    logic [CELL_W-1:0] tmp_next;
    logic [POS_W-1:0]  i_reg;
    logic [POS_W-1:0]  i_next;
    logic [POS_W-1:0]  m_reg;
    logic [POS_W-1:0]  m_next;

    logic [CALC_W-1:0]     k_cur;
    logic [CALC_W-1:0]     k_resized;
    logic [CALC_W-1:0]     p1_ext;
    logic [CALC_W-1:0]     p2_ext;
    kind_t                 kind_in;
    logic                  err_in;
    logic [CELL_SLOTS-1:0] used;
    logic                  fill;
    logic                  rebuild_last;
    logic [IDX_W-1:0]      rd_addr;
    logic [CELL_W-1:0]     rd_data;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [CELL_W-1:0]     wr_data;

    assign k_cur  = CALC_W'(klen_reg);
    assign p1_ext = CALC_W'(first_pos);
    assign p2_ext = CALC_W'(second_pos);

    // move decode on the incoming beat
    always_comb
    begin
        if (operation == OP_LOAD)
            kind_in = KIND_LOAD;
        else if (draw < resize_thr)
            kind_in = KIND_RESIZE;
        else if (draw < exchange_thr)
            kind_in = KIND_EXCHANGE;
        else
            kind_in = KIND_REORDER;
    end

    always_comb
    begin
        case (kind_in)
            KIND_EXCHANGE:
                err_in = !((p1_ext < k_cur) && (p2_ext >= k_cur)
                           && (p2_ext < CALC_W'(ALPHABET_SIZE)));
            KIND_REORDER:
                err_in = !((p1_ext < k_cur) && (p2_ext < k_cur));
            default:
                err_in = 1'b0;
        endcase
    end

    // limits override the coin
    always_comb
    begin
        if (k_cur <= CALC_W'(KEYWORD_MIN))
            k_resized = k_cur + CALC_W'(1);
        else if (k_cur >= CALC_W'(KEYWORD_MAX))
            k_resized = k_cur - CALC_W'(1);
        else if (coin)
            k_resized = k_cur + CALC_W'(1);
        else
            k_resized = k_cur - CALC_W'(1);
    end

    always_comb
    begin
        klen_next = klen_reg;
        kind_next = kind_reg;
        err_next  = err_reg;
        p1_next   = p1_reg;
        p2_next   = p2_reg;
        if (cmd.accept)
        begin
            kind_next = kind_in;
            err_next  = err_in;
            p1_next   = first_pos;
            p2_next   = second_pos;
            if (kind_in == KIND_LOAD)
                klen_next = KLEN_W'(clamp_len(CALC_W'(load_keyword_length)));
            else if (kind_in == KIND_RESIZE)
                klen_next = KLEN_W'(clamp_len(k_resized));
        end
    end

    // letters taken by the keyword
    always_comb
    begin
        used = '0;
        for (int j = 0; j < KEYWORD_MAX; j++)
        begin
            if (CALC_W'(j) < k_cur)
                used[cells_reg[j]] = 1'b1;
        end
    end

    // one candidate letter per cycle, placed at the next free tail cell
    assign fill = (cmd.op == DP_REBUILD) && !used[IDX_W'(i_reg)]
                  && (m_reg < POS_W'(ALPHABET_SIZE));
    assign rebuild_last = (i_reg == POS_W'(ALPHABET_SIZE - 1));

    always_comb
    begin
        i_next = i_reg;
        m_next = m_reg;
        if (cmd.rebuild_start)
        begin
            i_next = '0;
            m_next = POS_W'(klen_next);
        end
        else if (cmd.op == DP_REBUILD)
        begin
            i_next = i_reg + POS_W'(1);
            if (fill)
                m_next = m_reg + POS_W'(1);
        end
    end

    assign rd_addr = (cmd.op == DP_SWAP_A) ? p1_reg : p2_reg;
    assign rd_data = cells_reg[rd_addr];

    always_comb
    begin
        tmp_next = tmp_reg;
        wr_en    = 1'b0;
        wr_addr  = p1_reg;
        wr_data  = rd_data;
        case (cmd.op)
            DP_SWAP_A:
                tmp_next = rd_data;
            DP_SWAP_B:
            begin
                wr_en   = 1'b1;
                wr_addr = p1_reg;
                wr_data = rd_data;
            end
            DP_SWAP_C:
            begin
                wr_en   = 1'b1;
                wr_addr = p2_reg;
                wr_data = tmp_reg;
            end
            DP_REBUILD:
            begin
                wr_en   = fill;
                wr_addr = IDX_W'(m_reg);
                wr_data = CELL_W'(i_reg);
            end
            default:
                wr_en = 1'b0;
        endcase
    end

    always_comb
    begin
        cells_next = cells_reg;
        if (cmd.accept && (kind_in == KIND_LOAD))
        begin
            for (int j = 0; j < HALF_CELLS; j++)
            begin
                cells_next[j]              = load_lower_half[j*CELL_W +: CELL_W];
                cells_next[HALF_CELLS + j] = load_upper_half[j*CELL_W +: CELL_W];
            end
        end
        else if (wr_en)
        begin
            cells_next[wr_addr] = wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < CELL_SLOTS; j++)
                cells_reg[j] <= (j < PACKED_CELLS) ? CELL_W'(j) : '0;
            klen_reg <= KLEN_W'(clamp_len(CALC_W'(KEYWORD_MIN)));
            kind_reg <= KIND_LOAD;
            err_reg  <= 1'b0;
            i_reg    <= '0;
            m_reg    <= '0;
        end
        else
        begin
            cells_reg <= cells_next;
            klen_reg  <= klen_next;
            kind_reg  <= kind_next;
            err_reg   <= err_next;
            i_reg     <= i_next;
            m_reg     <= m_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg  <= p1_next;
        p2_reg  <= p2_next;
        tmp_reg <= tmp_next;
    end

    always_comb
    begin
        for (int j = 0; j < HALF_CELLS; j++)
        begin
            alphabet_lower_half[j*CELL_W +: CELL_W] = cells_reg[j];
            alphabet_upper_half[j*CELL_W +: CELL_W] = cells_reg[HALF_CELLS + j];
        end
    end

    assign keyword_length_now = OUT_LEN_W'(klen_reg);
    assign move_kind          = kind_reg;
    assign position_error     = err_reg;

    assign status = '{kind_in: kind_in, err_in: err_in, kind: kind_reg,
                      rebuild_last: rebuild_last};

    `KAMU_ASSERT_NOW(a_tail_only_write, clk, rst_n, (cmd.op == DP_REBUILD) && wr_en, m_reg >= klen_reg)
    `KAMU_ASSERT_NEXT(a_len_in_range, clk, rst_n, cmd.accept,
        (klen_reg >= KEYWORD_MIN) && (klen_reg <= KEYWORD_MAX))
    `KAMU_ASSERT_NOW(a_swap_no_error, clk, rst_n, cmd.op == DP_SWAP_C, !err_reg)

endmodule

@@ tb/testbench.sv @@
// testbench of the keyed alphabet mutation unit: directed and random load and move beats,
// each result checked against an in-bench model of the alphabet; thresholds set over apb
// depends on kamu_pkg and keyed_alphabet_mutation_unit
`timescale 1ns / 1ps

module testbench;
    import kamu_pkg::*;

    localparam int NUM_LETTERS = ALPHABET_SIZE_DEF;
    localparam int KW_MIN      = KEYWORD_MIN_DEF;
    localparam int KW_MAX      = KEYWORD_MAX_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;
    localparam int GAP_MAX     = 19;
    localparam int MAX_REPORTS = 60;
    localparam logic [THR_W-1:0] THR_TOP = '1;

    typedef struct {
        logic                  operation;
        logic [HALF_W-1:0]     lower;
        logic [HALF_W-1:0]     upper;
        logic [LOAD_LEN_W-1:0] load_len;
        logic [THR_W-1:0]      draw;
        logic                  coin;
        logic [IDX_W-1:0]      first_pos;
        logic [IDX_W-1:0]      second_pos;
    } mutation_beat_t;

    typedef struct {
        logic [HALF_W-1:0]    lower;
        logic [HALF_W-1:0]    upper;
        logic [OUT_LEN_W-1:0] keyword_len;
        kind_t                kind;
        logic                 pos_error;
    } alphabet_view_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic                   operation;
    logic [HALF_W-1:0]      load_lower_half;
    logic [HALF_W-1:0]      load_upper_half;
    logic [LOAD_LEN_W-1:0]  load_keyword_length;
    logic [THR_W-1:0]       draw;
    logic                   coin;
    logic [IDX_W-1:0]       first_pos;
    logic [IDX_W-1:0]       second_pos;
    logic                   done;
    logic [HALF_W-1:0]      alphabet_lower_half;
    logic [HALF_W-1:0]      alphabet_upper_half;
    logic [OUT_LEN_W-1:0]   keyword_length_now;
    logic [1:0]             move_kind;
    logic                   position_error;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // model of the block
    logic [CELL_W-1:0]      model_letters [NUM_LETTERS];
    int unsigned            model_kw_len;
    logic [THR_W-1:0]       model_resize_thr;
    logic [THR_W-1:0]       model_exchange_thr;
    alphabet_view_t         pending_views [$];

    int                     mismatch_count = 0;
    int                     stall_cycles = 0;

    keyed_alphabet_mutation_unit i_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .busy                (busy),
        .operation           (operation),
        .load_lower_half     (load_lower_half),
        .load_upper_half     (load_upper_half),
        .load_keyword_length (load_keyword_length),
        .draw                (draw),
        .coin                (coin),
        .first_pos           (first_pos),
        .second_pos          (second_pos),
        .done                (done),
        .alphabet_lower_half (alphabet_lower_half),
        .alphabet_upper_half (alphabet_upper_half),
        .keyword_length_now  (keyword_length_now),
        .move_kind           (move_kind),
        .position_error      (position_error),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [HALF_W-1:0] pack_half(input logic [CELL_W-1:0] letters [NUM_LETTERS],
                                                    input int unsigned base);
        logic [HALF_W-1:0] half_bits;
        half_bits = '0;
        for (int i = 0; i < HALF_CELLS; i++)
            half_bits[i*CELL_W +: CELL_W] = letters[base + i];
        return half_bits;
    endfunction

    function automatic logic [HALF_W-1:0] rand_half();
        return HALF_W'({$urandom(), $urandom()});
    endfunction

    function automatic void reset_model();
        for (int i = 0; i < NUM_LETTERS; i++)
            model_letters[i] = CELL_W'(i);
        model_kw_len       = KW_MIN;
        model_resize_thr   = RESIZE_THR_RESET;
        model_exchange_thr = EXCHANGE_THR_RESET;
    endfunction

    // unused letters go to the tail in ascending order while any are left
    function automatic void rebuild_tail();
        logic [CELL_SLOTS-1:0] taken;
        int unsigned fill;
        taken = '0;
        for (int i = 0; i < model_kw_len; i++)
            taken[model_letters[i]] = 1'b1;
        fill = model_kw_len;
        for (int i = 0; i < NUM_LETTERS && fill < NUM_LETTERS; i++)
        begin
            if (!taken[i])
            begin
                model_letters[fill] = CELL_W'(i);
                fill++;
            end
        end
    endfunction

    function automatic void swap_letters(input int unsigned a, input int unsigned b);
        logic [CELL_W-1:0] held;
        held             = model_letters[a];
        model_letters[a] = model_letters[b];
        model_letters[b] = held;
    endfunction

    // applies one beat to the model and returns the alphabet the block should show
    function automatic alphabet_view_t mutate_alphabet(input mutation_beat_t b);
        alphabet_view_t view;
        int unsigned k;
        int unsigned p1;
        int unsigned p2;
        view.kind      = KIND_LOAD;
        view.pos_error = 1'b0;
        if (b.operation == OP_LOAD)
        begin
            for (int i = 0; i < HALF_CELLS; i++)
            begin
                model_letters[i]              = b.lower[i*CELL_W +: CELL_W];
                model_letters[HALF_CELLS + i] = b.upper[i*CELL_W +: CELL_W];
            end
            if (b.load_len < KW_MIN)
                model_kw_len = KW_MIN;
            else if (b.load_len > KW_MAX)
                model_kw_len = KW_MAX;
            else
                model_kw_len = 32'(b.load_len);
        end
        else
        begin
            k  = model_kw_len;
            p1 = 32'(b.first_pos);
            p2 = 32'(b.second_pos);
            if (b.draw < model_resize_thr)
            begin
                view.kind = KIND_RESIZE;
                // at a limit the coin is ignored
                if (k <= KW_MIN)
                    k++;
                else if (k >= KW_MAX)
                    k--;
                else if (b.coin)
                    k++;
                else
                    k--;
                model_kw_len = k;
                rebuild_tail();
            end
            else if (b.draw < model_exchange_thr)
            begin
                view.kind = KIND_EXCHANGE;
                if (p1 < k && p2 >= k && p2 < NUM_LETTERS)
                begin
                    swap_letters(p1, p2);
                    rebuild_tail();
                end
                else
                    view.pos_error = 1'b1;
            end
            else
            begin
                view.kind = KIND_REORDER;
                if (p1 < k && p2 < k)
                    swap_letters(p1, p2);
                else
                    view.pos_error = 1'b1;
            end
        end
        view.lower       = pack_half(model_letters, 0);
        view.upper       = pack_half(model_letters, HALF_CELLS);
        view.keyword_len = OUT_LEN_W'(model_kw_len);
        return view;
    endfunction

    function automatic mutation_beat_t load_beat(input logic [HALF_W-1:0] lower,
                                                 input logic [HALF_W-1:0] upper,
                                                 input logic [LOAD_LEN_W-1:0] len);
        mutation_beat_t b;
        b.operation  = OP_LOAD;
        b.lower      = lower;
        b.upper      = upper;
        b.load_len   = len;
        b.draw       = THR_W'($urandom());
        b.coin       = 1'($urandom());
        b.first_pos  = IDX_W'($urandom());
        b.second_pos = IDX_W'($urandom());
        return b;
    endfunction

    function automatic mutation_beat_t move_beat(input logic [THR_W-1:0] d, input logic c,
                                                 input int unsigned p1, input int unsigned p2);
        mutation_beat_t b;
        b.operation  = OP_MOVE;
        b.lower      = rand_half();
        b.upper      = rand_half();
        b.load_len   = LOAD_LEN_W'($urandom());
        b.draw       = d;
        b.coin       = c;
        b.first_pos  = IDX_W'(p1);
        b.second_pos = IDX_W'(p2);
        return b;
    endfunction

    // well-formed alphabet: shuffled keyword, then the rest in ascending order
    function automatic mutation_beat_t keyed_load(input int unsigned kw_len);
        logic [CELL_W-1:0] letters [NUM_LETTERS];
        logic [CELL_W-1:0] held;
        logic [NUM_LETTERS-1:0] in_keyword;
        int unsigned pick;
        int unsigned fill;
        for (int i = 0; i < NUM_LETTERS; i++)
            letters[i] = CELL_W'(i);
        for (int i = NUM_LETTERS - 1; i > 0; i--)
        begin
            pick          = $urandom_range(0, i);
            held          = letters[i];
            letters[i]    = letters[pick];
            letters[pick] = held;
        end
        in_keyword = '0;
        for (int i = 0; i < kw_len; i++)
            in_keyword[letters[i]] = 1'b1;
        fill = kw_len;
        for (int i = 0; i < NUM_LETTERS; i++)
        begin
            if (!in_keyword[i])
            begin
                letters[fill] = CELL_W'(i);
                fill++;
            end
        end
        return load_beat(pack_half(letters, 0), pack_half(letters, HALF_CELLS),
                         LOAD_LEN_W'(kw_len));
    endfunction

    // mostly positions that fit the move the draw selects, some out of range
    function automatic mutation_beat_t random_move();
        logic [THR_W-1:0] d;
        int unsigned k;
        d = THR_W'($urandom());
        k = model_kw_len;
        if ($urandom_range(0, 9) < 2 || d < model_resize_thr)
            return move_beat(d, 1'($urandom()), $urandom_range(0, 31), $urandom_range(0, 31));
        else if (d < model_exchange_thr)
            return move_beat(d, 1'($urandom()), $urandom_range(0, k - 1),
                             $urandom_range(k, NUM_LETTERS - 1));
        else
            return move_beat(d, 1'($urandom()), $urandom_range(0, k - 1),
                             $urandom_range(0, k - 1));
    endfunction

    function automatic mutation_beat_t random_beat();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return keyed_load($urandom_range(KW_MIN, KW_MAX));
        else if (roll < 11)
            return load_beat(rand_half(), rand_half(), LOAD_LEN_W'($urandom()));
        else
            return random_move();
    endfunction

    task automatic send_beat(input mutation_beat_t b, input int unsigned gap);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        operation           <= b.operation;
        load_lower_half     <= b.lower;
        load_upper_half     <= b.upper;
        load_keyword_length <= b.load_len;
        draw                <= b.draw;
        coin                <= b.coin;
        first_pos           <= b.first_pos;
        second_pos          <= b.second_pos;
        start               <= 1'b1;
        do @(posedge clk); while (busy);
        pending_views.push_back(mutate_alphabet(b));
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_views.size() != 0 || busy)
            @(negedge clk);
    endtask

    task automatic apb_access(input logic is_write, input logic reg_idx,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_threshold(input logic reg_idx, input logic [THR_W-1:0] value);
        logic [APB_DATA_W-1:0] readback;
        wait_for_results();
        // upper data bits are don't-care on write
        apb_access(1'b1, reg_idx, {16'($urandom()), value}, readback);
        if (reg_idx == REG_IDX_RESIZE)
            model_resize_thr = value;
        else
            model_exchange_thr = value;
        apb_access(1'b0, reg_idx, '0, readback);
        if (readback[THR_W-1:0] !== value)
        begin
            $display("%0t: threshold %0d readback expected %h actual %h",
                     $time, reg_idx, value, readback[THR_W-1:0]);
            mismatch_count++;
        end
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            if (mismatch_count < MAX_REPORTS)
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        alphabet_view_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_views.size() == 0)
            begin
                if (mismatch_count < MAX_REPORTS)
                    $display("%0t: result with no beat pending, expected none actual %h %h",
                             $time, alphabet_upper_half, alphabet_lower_half);
                mismatch_count++;
            end
            else
            begin
                want = pending_views.pop_front();
                check_field("alphabet_lower_half", 64'(want.lower), 64'(alphabet_lower_half));
                check_field("alphabet_upper_half", 64'(want.upper), 64'(alphabet_upper_half));
                check_field("keyword_length_now", 64'(want.keyword_len),
                            64'(keyword_length_now));
                check_field("move_kind", 64'(want.kind), 64'(move_kind));
                check_field("position_error", 64'(want.pos_error), 64'(position_error));
            end
        end
    end

    // cycles with neither a beat taken nor a result shown
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("Verification failed");
        $finish;
    end

    task automatic test_reset_state();
        // equal keyword positions leave the reset alphabet as it is
        send_beat(move_beat(THR_TOP, 1'b0, 0, 0), 0);
        send_beat(move_beat(THR_TOP, 1'b1, KW_MIN - 1, KW_MIN - 1), 0);
    endtask

    task automatic test_load_extremes();
        mutation_beat_t b;
        send_beat(load_beat('0, '0, 4'd0), $urandom_range(0, 3));
        // letters beyond the alphabet, length saturates high
        send_beat(load_beat('1, '1, 4'd15), $urandom_range(0, 3));
        send_beat(move_beat('0, 1'b0, 0, 0), 0);
        // duplicate letters then a tail rebuild
        send_beat(load_beat('0, '0, 4'd2), $urandom_range(0, 3));
        send_beat(move_beat(model_resize_thr, 1'b0, 0, KW_MIN), 0);
        b = keyed_load(KW_MAX);
        b.load_len = 4'd13;
        send_beat(b, $urandom_range(0, 3));
        send_beat(load_beat(rand_half(), rand_half(), 4'd14), 0);
        send_beat(load_beat(rand_half(), rand_half(), 4'd1), 0);
        send_beat(move_beat(16'd1, 1'b1, 0, 0), 0);
    endtask

    task automatic test_resize_limits();
        send_beat(keyed_load(KW_MIN), 0);
        send_beat(move_beat('0, 1'b0, 0, 0), $urandom_range(0, 3));
        send_beat(move_beat(THR_W'(model_resize_thr - 1), 1'b0, 31, 31), 0);
        send_beat(keyed_load(KW_MAX), 0);
        send_beat(move_beat('0, 1'b1, 0, 0), 0);
        send_beat(move_beat(16'd7, 1'b1, 5, 20), $urandom_range(0, 3));
    endtask

    task automatic test_exchange();
        send_beat(keyed_load(5), 0);
        send_beat(move_beat(THR_W'(model_exchange_thr - 1), 1'b0, 4, 5), 0);
        send_beat(move_beat(model_resize_thr, 1'b1, 0, NUM_LETTERS - 1), $urandom_range(0, 3));
        send_beat(move_beat(model_resize_thr, 1'b0, 5, 10), 0);
        send_beat(move_beat(model_resize_thr, 1'b0, 0, 4), 0);
        send_beat(move_beat(model_resize_thr, 1'b0, 0, NUM_LETTERS), 0);
        send_beat(move_beat(model_resize_thr, 1'b0, 31, 31), 0);
    endtask

    task automatic test_reorder();
        send_beat(move_beat(model_exchange_thr, 1'b0, 2, 2), 0);
        send_beat(move_beat(model_exchange_thr, 1'b1, 0, 4), $urandom_range(0, 3));
        send_beat(move_beat(THR_TOP, 1'b0, 4, 0), 0);
        send_beat(move_beat(THR_TOP, 1'b0, 5, 0), 0);
        send_beat(move_beat(THR_TOP, 1'b1, 0, 31), 0);
    endtask

    task automatic test_threshold_registers();
        set_threshold(REG_IDX_RESIZE, '0);
        set_threshold(REG_IDX_EXCHANGE, '0);
        repeat (6) send_beat(random_move(), $urandom_range(0, GAP_MAX));
        set_threshold(REG_IDX_RESIZE, THR_TOP);
        set_threshold(REG_IDX_EXCHANGE, THR_TOP);
        repeat (6) send_beat(random_move(), $urandom_range(0, GAP_MAX));
        send_beat(move_beat(THR_TOP, 1'b1, 1, 2), 0);
        // exchange threshold below resize: no exchange at all
        set_threshold(REG_IDX_RESIZE, 16'd40000);
        set_threshold(REG_IDX_EXCHANGE, 16'd1000);
        repeat (6) send_beat(random_move(), $urandom_range(0, GAP_MAX));
        set_threshold(REG_IDX_RESIZE, RESIZE_THR_RESET);
        set_threshold(REG_IDX_EXCHANGE, EXCHANGE_THR_RESET);
    endtask

    task automatic test_random(input int unsigned count, input int unsigned gap_max);
        logic burst;
        burst = 1'b0;
        for (int n = 0; n < count; n++)
        begin
            // stretches of back-to-back beats between idling ones
            if (n % 16 == 0)
                burst = ($urandom_range(0, 3) == 0);
            send_beat(random_beat(), burst ? 0 : $urandom_range(0, gap_max));
            if (n % 100 == 99)
                wait_for_results();
        end
    endtask

    initial
    begin
        rst_n               = 1'b0;
        start               = 1'b0;
        operation           = OP_LOAD;
        load_lower_half     = '0;
        load_upper_half     = '0;
        load_keyword_length = '0;
        draw                = '0;
        coin                = 1'b0;
        first_pos           = '0;
        second_pos          = '0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        reset_model();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_load_extremes();
        test_resize_limits();
        test_exchange();
        test_reorder();
        test_threshold_registers();
        test_random(150, 0);
        test_random(250, GAP_MAX);
        set_threshold(REG_IDX_RESIZE, 16'd20000);
        set_threshold(REG_IDX_EXCHANGE, 16'd45000);
        test_random(200, GAP_MAX);
        set_threshold(REG_IDX_RESIZE, THR_TOP);
        set_threshold(REG_IDX_EXCHANGE, '0);
        test_random(50, GAP_MAX);
        set_threshold(REG_IDX_RESIZE, '0);
        set_threshold(REG_IDX_EXCHANGE, THR_TOP);
        test_random(100, GAP_MAX);

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_views.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/kamu_pkg.sv
hw/rtl/kamu_regs.sv
hw/rtl/kamu_ctrl.sv
hw/rtl/kamu_datapath.sv
hw/rtl/keyed_alphabet_mutation_unit.sv
tb/testbench.sv
